// ===== rtl/tfsp_pkg.sv =====
// Package for the TDMA frame slot planner: payload structs, state and status codes,
// the per-mode slot tables and the widths shared by the planner and its divider.
// No dependencies.
package tfsp_pkg;

   localparam int DEF_MAX_SECONDS = 10;
   localparam int DEF_MAX_FRAMES  = 64;

   localparam int SEC_US       = 1000000;
   localparam int SEC_W        = 20;
   localparam int SLOT_BASE_US = 1024;

   localparam int MODE_W     = 8;
   localparam int BLOCKS_W   = 8;
   localparam int SEL_W      = 3;
   localparam int BCN_W      = 17;
   localparam int SLOT_W     = 26;
   localparam int GAP_W      = 15;
   localparam int PERIOD_W   = 28;
   localparam int COUNT_W    = 7;
   localparam int STATUS_W   = 2;
   localparam int SHIFT_W    = 5;

   localparam logic [MODE_W-1:0] MODE_FIRST = MODE_W'(5);
   localparam logic [MODE_W-1:0] MODE_LAST  = MODE_W'(11);
   localparam logic [MODE_W-1:0] MODE_ALT   = MODE_W'(18);
   localparam logic [SEL_W-1:0]  SEL_ALT    = SEL_W'(7);

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_MODE   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_BLK   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_SUPER = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]   rate_mode;
      logic [BLOCKS_W-1:0] brd_blocks;
      logic [BLOCKS_W-1:0] ul_blocks;
      logic [BLOCKS_W-1:0] dl_blocks;
      logic [BLOCKS_W-1:0] super_frames;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BCN_W-1:0]    bcn_slot_len;
      logic [SLOT_W-1:0]   brd_slot_len;
      logic [SLOT_W-1:0]   ul_slot_len;
      logic [SLOT_W-1:0]   dl_slot_len;
      logic [GAP_W-1:0]    brd_gap;
      logic [GAP_W-1:0]    ul_gap;
      logic [GAP_W-1:0]    dl_gap;
      logic [PERIOD_W-1:0] frame_period;
      logic [COUNT_W-1:0]  frame_count;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SLOTS,
      ST_RAW1,
      ST_RAW2,
      ST_DIVGO,
      ST_DIV,
      ST_WALK,
      ST_NEXT,
      ST_FINISH
   } state_type;

   function automatic logic [BCN_W-1:0] bcn_len(input logic [SEL_W-1:0] sel);
      logic [BCN_W-1:0] v;
      unique case (sel)
         3'd0:    v = BCN_W'(69583);
         3'd1:    v = BCN_W'(36340);
         3'd2:    v = BCN_W'(19129);
         3'd3:    v = BCN_W'(10732);
         default: v = BCN_W'(6510);
      endcase
      return v;
   endfunction

   function automatic logic [GAP_W-1:0] gap_len(input logic [SEL_W-1:0] sel);
      logic [GAP_W-1:0] v;
      unique case (sel)
         3'd0:    v = GAP_W'(21492);
         3'd1:    v = GAP_W'(19728);
         3'd2:    v = GAP_W'(12000);
         3'd3:    v = GAP_W'(5600);
         3'd4:    v = GAP_W'(2800);
         3'd5:    v = GAP_W'(1400);
         default: v = GAP_W'(800);
      endcase
      return v;
   endfunction

   // Slot bodies are (2*blocks+1) times a power of two, from 2^17 down to 2^11.
   function automatic logic [SHIFT_W-1:0] body_shift(input logic [SEL_W-1:0] sel);
      logic [SHIFT_W-1:0] v;
      unique case (sel)
         3'd0:    v = SHIFT_W'(17);
         3'd1:    v = SHIFT_W'(16);
         3'd2:    v = SHIFT_W'(15);
         3'd3:    v = SHIFT_W'(14);
         3'd4:    v = SHIFT_W'(13);
         3'd5:    v = SHIFT_W'(12);
         default: v = SHIFT_W'(11);
      endcase
      return v;
   endfunction

   function automatic logic [SLOT_W-1:0] slot_len(input logic [SEL_W-1:0]    sel,
                                                  input logic [BLOCKS_W-1:0] blocks);
      logic [SLOT_W-1:0] odd;
      logic [SLOT_W-1:0] body;
      odd  = SLOT_W'({blocks, 1'b1});
      body = odd << body_shift(sel);
      return SLOT_W'(SLOT_BASE_US) + body + SLOT_W'(gap_len(sel));
   endfunction

endpackage

// ===== rtl/tdma_frame_slot_planner_top.sv =====
// Top level of the TDMA frame slot planner: request decode, slot sums, frame search
// sequencer and result register. Depends on tfsp_pkg and tfsp_div.

// The planner takes one request beat and returns one result beat. A request with a bad
// rate mode, a zero uplink or downlink count, or a zero superframe count goes straight
// to the finish state and is answered with an error status and all other fields zero. A
// good request first builds the beacon, broadcast, uplink and downlink slot lengths and
// their raw sum in the states ST_SLOTS, ST_RAW1 and ST_RAW2, then searches frame counts
// that are multiples of the superframe count, up to MAX_FRAMES. For each such count a
// serial divider splits one second into quotient and remainder, and quotient and
// remainder accumulators then walk the seconds 1..MAX_SECONDS. Larger superframe
// counts leave fewer frame counts to search. The shortest period that divides a
// whole number of seconds exactly and is not below the raw sum wins; on a tie the
// smaller number of seconds wins. When nothing fits, the raw sum is returned with a
// frame count of one. req_stall is high after the accepted beat until the result is
// loaded into the output register, and a new request can be taken while that result
// still waits on rsp_stall.
module tdma_frame_slot_planner_top #(
   parameter int MAX_SECONDS = tfsp_pkg::DEF_MAX_SECONDS,
   parameter int MAX_FRAMES  = tfsp_pkg::DEF_MAX_FRAMES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tfsp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tfsp_pkg::rsp_type rsp_data
);
   import tfsp_pkg::*;

   // The frame counter must hold MAX_FRAMES plus one more superframe step.
   localparam int F_W = $clog2(MAX_FRAMES + 256);
   localparam int S_W = $clog2(MAX_SECONDS + 1);
   localparam int Q_W = $clog2(MAX_SECONDS * SEC_US + 1);
   localparam logic [F_W-1:0] MAX_F = F_W'(MAX_FRAMES);
   localparam logic [S_W-1:0] MAX_S = S_W'(MAX_SECONDS);

   state_type state_ff, state_in;

   logic                req_take;
   logic                rsp_take;
   logic                rsp_load;
   logic                mode_ok;
   logic [SEL_W-1:0]    sel_dec;
   logic [STATUS_W-1:0] status_dec;

   // Strobes from the sequencer.
   logic start_div;
   logic walk_step;
   logic walk_last;
   logic next_f;
   logic more_f;

   logic                div_done;
   logic [SEC_W-1:0]    div_quot;
   logic [F_W-1:0]      div_rem;

   logic [STATUS_W-1:0] status_ff;
   logic [SEL_W-1:0]    sel_ff;
   logic [BLOCKS_W-1:0] brd_ff, ul_ff, dl_ff, sf_ff;
   logic [SLOT_W-1:0]   brd_len_ff, ul_len_ff, dl_len_ff;
   logic [PERIOD_W-1:0] part_ff;
   logic [PERIOD_W-1:0] raw_ff;
   logic [F_W-1:0]      f_ff;
   logic [F_W-1:0]      f_sum;
   logic [S_W-1:0]      s_ff;
   logic [Q_W-1:0]      q_ff, q_in;
   logic [F_W-1:0]      r_ff, r_in;
   logic [F_W:0]        r_sum;
   logic                carry;

   logic                eval_ff;
   logic                best_valid_ff;
   logic [PERIOD_W-1:0] best_period_ff;
   logic [S_W-1:0]      best_s_ff;
   logic [F_W-1:0]      best_f_ff;
   logic [PERIOD_W-1:0] cand;
   logic                better;

   logic                rsp_valid_ff;
   rsp_type             rsp_ff, rsp_in;

   // Request decode: mode to table row, then error priority.
   always_comb begin
      mode_ok = 1'b1;
      sel_dec = '0;
      if (req_data.rate_mode >= MODE_FIRST && req_data.rate_mode <= MODE_LAST) begin
         sel_dec = SEL_W'(req_data.rate_mode - MODE_FIRST);
      end else if (req_data.rate_mode == MODE_ALT) begin
         sel_dec = SEL_ALT;
      end else begin
         mode_ok = 1'b0;
      end
      if (!mode_ok) begin
         status_dec = STATUS_BAD_MODE;
      end else if (req_data.ul_blocks == '0 || req_data.dl_blocks == '0) begin
         status_dec = STATUS_ZERO_BLK;
      end else if (req_data.super_frames == '0) begin
         status_dec = STATUS_ZERO_SUPER;
      end else begin
         status_dec = STATUS_OK;
      end
   end

   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign f_sum     = f_ff + F_W'(sf_ff);

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = (status_dec == STATUS_OK) ? ST_SLOTS : ST_FINISH;
            end
         end
         ST_SLOTS: state_in = ST_RAW1;
         ST_RAW1:  state_in = ST_RAW2;
         ST_RAW2:  state_in = (f_ff <= MAX_F) ? ST_DIVGO : ST_FINISH;
         ST_DIVGO: state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_last) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT:  state_in = more_f ? ST_DIVGO : ST_FINISH;
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Output strobes of the sequencer.
   always_comb begin
      start_div = 1'b0;
      walk_step = 1'b0;
      walk_last = 1'b0;
      next_f    = 1'b0;
      more_f    = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_DIVGO:  start_div = 1'b1;
         ST_WALK: begin
            walk_step = 1'b1;
            walk_last = (s_ff + S_W'(1)) == MAX_S;
         end
         ST_NEXT: begin
            next_f = 1'b1;
            more_f = f_sum <= MAX_F;
         end
         ST_FINISH: rsp_load = !rsp_valid_ff || !rsp_stall;
         default: begin
         end
      endcase
   end

   tfsp_div #(
      .F_W (F_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (start_div),
      .divisor (f_ff),
      .done    (div_done),
      .quot    (div_quot),
      .rem     (div_rem)
   );

   // Walking one more second keeps quotient and remainder of s * 1e6 / f in step.
   always_comb begin
      r_sum = {1'b0, r_ff} + {1'b0, div_rem};
      carry = r_sum >= {1'b0, f_ff};
      r_in  = carry ? F_W'(r_sum - {1'b0, f_ff}) : r_sum[F_W-1:0];
      q_in  = q_ff + Q_W'(div_quot) + Q_W'(carry);
   end

   // An exact candidate not below the raw sum beats the best one if it is shorter, or as
   // short and earlier in seconds; frame counts rise monotonically so equal seconds never displace the best.
   always_comb begin
      cand   = PERIOD_W'(q_ff);
      better = (r_ff == '0) && (cand >= raw_ff) &&
               (!best_valid_ff || (cand < best_period_ff) ||
                ((cand == best_period_ff) && (s_ff < best_s_ff)));
   end

   always_comb begin
      rsp_in = '0;
      rsp_in.status = status_ff;
      if (status_ff == STATUS_OK) begin
         rsp_in.bcn_slot_len = bcn_len(sel_ff);
         rsp_in.brd_slot_len = brd_len_ff;
         rsp_in.ul_slot_len  = ul_len_ff;
         rsp_in.dl_slot_len  = dl_len_ff;
         rsp_in.brd_gap      = gap_len(sel_ff);
         rsp_in.ul_gap       = gap_len(sel_ff);
         rsp_in.dl_gap       = gap_len(sel_ff);
         if (best_valid_ff) begin
            rsp_in.frame_period = best_period_ff;
            rsp_in.frame_count  = best_f_ff[COUNT_W-1:0];
         end else begin
            rsp_in.frame_period = raw_ff;
            rsp_in.frame_count  = COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         eval_ff       <= 1'b0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         eval_ff  <= walk_step;
         if (req_take) begin
            best_valid_ff <= 1'b0;
         end else if (eval_ff && better) begin
            best_valid_ff <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (req_take) begin
         status_ff <= status_dec;
         sel_ff    <= sel_dec;
         brd_ff    <= req_data.brd_blocks;
         ul_ff     <= req_data.ul_blocks;
         dl_ff     <= req_data.dl_blocks;
         sf_ff     <= req_data.super_frames;
         f_ff      <= F_W'(req_data.super_frames);
      end else if (next_f) begin
         f_ff <= f_sum;
      end

      if (state_ff == ST_SLOTS) begin
         brd_len_ff <= slot_len(sel_ff, brd_ff);
         ul_len_ff  <= slot_len(sel_ff, ul_ff);
         dl_len_ff  <= slot_len(sel_ff, dl_ff);
      end
      if (state_ff == ST_RAW1) begin
         part_ff <= PERIOD_W'(bcn_len(sel_ff)) + PERIOD_W'(brd_len_ff) + PERIOD_W'(ul_len_ff);
      end
      if (state_ff == ST_RAW2) begin
         raw_ff <= part_ff + PERIOD_W'(dl_len_ff);
      end

      if (div_done) begin
         s_ff <= '0;
         q_ff <= '0;
         r_ff <= '0;
      end else if (walk_step) begin
         s_ff <= s_ff + S_W'(1);
         q_ff <= q_in;
         r_ff <= r_in;
      end

      if (eval_ff && better) begin
         best_period_ff <= cand;
         best_s_ff      <= s_ff;
         best_f_ff      <= f_ff;
      end

      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/tfsp_div.sv =====
// Radix-2 restoring divider of the constant one second (in microseconds) by a frame count.
// One quotient bit per cycle. Depends on tfsp_pkg.
module tfsp_div #(
   parameter int F_W = 9
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [F_W-1:0]            divisor,
   output logic                      done,
   output logic [tfsp_pkg::SEC_W-1:0] quot,
   output logic [F_W-1:0]            rem
);
   import tfsp_pkg::*;

   localparam int CNT_W = $clog2(SEC_W);
   localparam logic [SEC_W-1:0] DIVIDEND = SEC_W'(SEC_US);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [F_W-1:0]   rem_ff, rem_in;
   logic [SEC_W-1:0] quot_ff, quot_in;
   logic [F_W:0]     shifted;
   logic [F_W:0]     diff;
   logic             ge;

   always_comb begin
      shifted = {rem_ff, DIVIDEND[cnt_ff]};
      diff    = shifted - {1'b0, divisor};
      ge      = shifted >= {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(SEC_W - 1);
         rem_in  = '0;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[F_W-1:0] : shifted[F_W-1:0];
         quot_in = {quot_ff[SEC_W-2:0], ge};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule
